// ===== rtl/frame_checker_and_field_extractor_core_defines.svh =====
// Assertion macros for the frame checker port-level checks in fcfe_checker.
`ifndef FRAME_CHECKER_AND_FIELD_EXTRACTOR_CORE_DEFINES_SVH
`define FRAME_CHECKER_AND_FIELD_EXTRACTOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define FCFE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define FCFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/fcfe_pkg.sv =====
// Types, constants and helpers shared by the frame checker modules.
package fcfe_pkg;

   // Result item kinds carried on tuser
   localparam logic KindPayload = 1'b0;
   localparam logic KindVerdict = 1'b1;

   typedef enum logic [2:0] {
      VerdictOk        = 3'd0,
      VerdictWrongType = 3'd1,
      VerdictChecksum  = 3'd2,
      VerdictLength    = 3'd3,
      VerdictTooShort  = 3'd4
   } verdict_type;

   // Header layout (byte offsets within the frame)
   localparam logic [15:0] TypeOffset     = 16'd7;
   localparam logic [15:0] IdentFirst     = 16'd8;
   localparam logic [15:0] IdentLast      = 16'd15;
   localparam logic [15:0] LengthFirst    = 16'd16;
   localparam logic [15:0] LengthLast     = 16'd17;
   localparam logic [15:0] SumBytes       = 16'd18;
   localparam logic [15:0] ChecksumLast   = 16'd19;
   localparam logic [15:0] IndexFirst     = 16'd20;
   localparam logic [15:0] IndexLast      = 16'd23;
   localparam logic [15:0] PayloadOffset  = 16'd24;
   localparam logic [15:0] LengthBias     = 16'd4;
   localparam logic [16:0] MaxFrameBytes  = 17'd1024;
   localparam logic [15:0] PosSaturate    = 16'hffff;

   localparam logic [7:0] TypeReset = 8'd1;

   localparam int DataW = 128;

   localparam int QueueDepth = 8;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic             kind;
      logic [DataW-1:0] data;
      logic             last;
   } rsp_item_type;

   typedef struct packed {
      logic         pending;  // an item sits in the input register
      logic [1:0]   num;      // result items pushed this cycle
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

   function automatic logic [DataW-1:0] pack_data(
      input logic [7:0]  payload_byte,
      input logic [2:0]  verdict,
      input logic [15:0] payload_length,
      input logic [7:0]  packet_number,
      input logic [7:0]  packet_count,
      input logic [15:0] frame_sequence,
      input logic [63:0] device_ident
   );
      return {5'b0, device_ident, frame_sequence, packet_count, packet_number,
              payload_length, verdict, payload_byte};
   endfunction

endpackage

// ===== rtl/fcfe_parse.sv =====
// Input register, running frame state and per-byte result computation.
module fcfe_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tlast,
   input  logic                queue_room,
   output fcfe_pkg::push_type  push
);
   import fcfe_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic [7:0]  accepted_type_ff, accepted_type_in;
   logic [15:0] pos_ff, pos_in;
   logic [19:0] sum_ff, sum_in;
   logic [7:0]  low_ff, low_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] chk_ff, chk_in;
   logic [31:0] index_ff, index_in;
   logic [63:0] ident_ff, ident_in;

   // State after this byte, before the end-of-frame clear
   logic [19:0] sum_upd;
   logic [7:0]  low_upd, type_upd;
   logic [15:0] length_upd, chk_upd;
   logic [31:0] index_upd;
   logic [63:0] ident_upd;

   logic        is_payload;
   logic        is_verdict;
   logic [16:0] fold1;
   logic [15:0] fold2;
   logic [15:0] chk_calc;
   logic [15:0] plen;
   logic [15:0] body_len;
   verdict_type verdict;
   rsp_item_type pay_item, ver_item;

   assign req_tready       = queue_room;
   assign in_valid_in      = req_tvalid && req_tready;
   assign accepted_type_in = csr_wr_en ? csr_wr_data : accepted_type_ff;

   always_comb begin
      sum_upd    = sum_ff;
      low_upd    = low_ff;
      type_upd   = type_ff;
      length_upd = length_ff;
      chk_upd    = chk_ff;
      index_upd  = index_ff;
      ident_upd  = ident_ff;
      if (pos_ff < SumBytes) begin
         if (!pos_ff[0]) begin
            low_upd = in_byte_ff;
         end else begin
            sum_upd = sum_ff + {4'b0, in_byte_ff, low_ff};
         end
      end
      if (pos_ff == TypeOffset) begin
         type_upd = in_byte_ff;
      end
      if (pos_ff >= IdentFirst && pos_ff <= IdentLast) begin
         ident_upd = {ident_ff[55:0], in_byte_ff};
      end
      if (pos_ff == LengthFirst || pos_ff == LengthLast) begin
         length_upd = {length_ff[7:0], in_byte_ff};
      end
      if (pos_ff == SumBytes || pos_ff == ChecksumLast) begin
         chk_upd = {chk_ff[7:0], in_byte_ff};
      end
      if (pos_ff >= IndexFirst && pos_ff <= IndexLast) begin
         index_upd = {index_ff[23:0], in_byte_ff};
      end
   end

   // Checksum and type are settled by offset 23, so checks read the held state
   always_comb begin
      fold1    = {1'b0, sum_ff[15:0]} + {13'b0, sum_ff[19:16]};
      fold2    = fold1[15:0] + {15'b0, fold1[16]};
      chk_calc = ~fold2;
      plen     = length_upd - LengthBias;
      body_len = pos_ff - (PayloadOffset - 16'd1);
      priority if (pos_ff < PayloadOffset - 16'd1) begin
         verdict = VerdictTooShort;
      end else if (type_ff != accepted_type_ff) begin
         verdict = VerdictWrongType;
      end else if (chk_ff != chk_calc) begin
         verdict = VerdictChecksum;
      end else if ({1'b0, pos_ff} >= MaxFrameBytes || plen != body_len) begin
         verdict = VerdictLength;
      end else begin
         verdict = VerdictOk;
      end
   end

   always_comb begin
      is_payload = in_valid_ff && pos_ff >= PayloadOffset && {1'b0, pos_ff} < MaxFrameBytes;
      is_verdict = in_valid_ff && in_last_ff;

      pay_item.kind = KindPayload;
      pay_item.data = pack_data(in_byte_ff, 3'b0, 16'b0, 8'b0, 8'b0, 16'b0, 64'b0);
      pay_item.last = !in_last_ff;

      ver_item.kind = KindVerdict;
      ver_item.data = pack_data(8'b0, verdict, plen, index_upd[31:24], index_upd[23:16],
                                index_upd[15:0], ident_upd);
      ver_item.last = 1'b1;

      push.pending = in_valid_ff;
      push.num     = {1'b0, is_payload} + {1'b0, is_verdict};
      push.item0   = is_payload ? pay_item : ver_item;
      push.item1   = ver_item;
   end

   always_comb begin
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      low_in    = low_ff;
      type_in   = type_ff;
      length_in = length_ff;
      chk_in    = chk_ff;
      index_in  = index_ff;
      ident_in  = ident_ff;
      if (in_valid_ff) begin
         if (in_last_ff) begin
            // clear for the next frame
            pos_in    = '0;
            sum_in    = '0;
            low_in    = '0;
            type_in   = '0;
            length_in = '0;
            chk_in    = '0;
            index_in  = '0;
            ident_in  = '0;
         end else begin
            sum_in    = sum_upd;
            low_in    = low_upd;
            type_in   = type_upd;
            length_in = length_upd;
            chk_in    = chk_upd;
            index_in  = index_upd;
            ident_in  = ident_upd;
            if (pos_ff != PosSaturate) begin
               pos_in = pos_ff + 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         accepted_type_ff <= TypeReset;
         pos_ff           <= '0;
         sum_ff           <= '0;
         low_ff           <= '0;
         type_ff          <= '0;
         length_ff        <= '0;
         chk_ff           <= '0;
         index_ff         <= '0;
         ident_ff         <= '0;
      end else begin
         in_valid_ff      <= in_valid_in;
         accepted_type_ff <= accepted_type_in;
         pos_ff           <= pos_in;
         sum_ff           <= sum_in;
         low_ff           <= low_in;
         type_ff          <= type_in;
         length_ff        <= length_in;
         chk_ff           <= chk_in;
         index_ff         <= index_in;
         ident_ff         <= ident_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

endmodule

// ===== rtl/fcfe_queue.sv =====
// Result queue that takes up to two items a cycle and hands out one.
module fcfe_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  fcfe_pkg::push_type      push,
   output logic                    queue_room,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [fcfe_pkg::DataW-1:0] rsp_tdata,
   output logic                    rsp_tuser,
   output logic                    rsp_tlast
);
   import fcfe_pkg::*;

   rsp_item_type           entries_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic [QueuePtrW-1:0]   wr_ptr_next;
   logic                   pop;
   logic [QueueCntW:0]     committed;

   assign pop         = (count_ff != '0) && rsp_tready;
   assign wr_ptr_next = wr_ptr_ff + QueuePtrW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QueuePtrW'(push.num);
      rd_ptr_in = pop ? rd_ptr_ff + QueuePtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + QueueCntW'(push.num) - QueueCntW'(pop);
      // leave space for the item in the input register and one more behind it
      committed  = {1'b0, count_ff} + (push.pending ? (QueueCntW+1)'(2) : '0);
      queue_room = committed <= (QueueCntW+1)'(QueueDepth - 2);
   end

   assign rsp_tvalid = count_ff != '0;
   assign rsp_tdata  = entries_ff[rd_ptr_ff].data;
   assign rsp_tuser  = entries_ff[rd_ptr_ff].kind;
   assign rsp_tlast  = entries_ff[rd_ptr_ff].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.num == 2'd2) begin
         entries_ff[wr_ptr_next] <= push.item1;
      end
   end

endmodule

// ===== rtl/frame_checker_and_field_extractor_core.sv =====
// Byte-stream frame checker: runs the header checks and forwards the payload, one byte per cycle.
// A frame arrives one byte per req item, tlast on its final byte. Each accepted byte lands in an
// input register and is worked in the next cycle against the running header state (byte offset,
// 20-bit checksum accumulator, captured header fields); its results enter an eight-entry result
// queue at the following edge, from whose head rsp shows them. One byte is taken every cycle
// while rsp keeps up. Payload bytes from offset 24 up to offset 1023 come out as tuser=0
// items; the last byte adds a tuser=1 verdict item (after the payload item when both occur),
// and that last byte can therefore put two items on rsp. req_tready falls when the queue cannot
// hold what is in flight. The accepted type register resets to 1 and is written through
// csr_wr_en/csr_wr_data; the user must write it only while no frame is in progress, as the
// block itself does not enforce this.
module frame_checker_and_field_extractor_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data,   // accepted_type
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,     // [7:0] byte_value
   input  logic         req_tlast,     // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [7:0] payload_byte, [10:8] verdict, [26:11] payload_length, [34:27] packet_number,
   // [42:35] packet_count, [58:43] frame_sequence, [122:59] device_ident, [127:123] zero
   output logic [127:0] rsp_tdata,
   output logic         rsp_tuser,     // item_kind
   output logic         rsp_tlast      // end_of_run
);
   import fcfe_pkg::*;

   push_type push;
   logic     queue_room;

   fcfe_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .queue_room  (queue_room),
      .push        (push)
   );

   fcfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .queue_room (queue_room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/fcfe_checker.sv =====
// Port-level checks for the frame checker, bound to the top level.
`include "frame_checker_and_field_extractor_core_defines.svh"

module fcfe_checker (
   input logic         clock,
   input logic         reset,
   input logic         csr_wr_en,
   input logic [7:0]   csr_wr_data,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [7:0]   req_tdata,
   input logic         req_tlast,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         rsp_tuser,
   input logic         rsp_tlast
);
   import fcfe_pkg::*;

   `FCFE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "rsp item changed while stalled")

   `FCFE_ASSERT_NOW(a_payload_clean, clock, reset, rsp_tvalid && rsp_tuser == KindPayload, rsp_tdata[127:8] == '0, "payload item carries verdict fields")

   `FCFE_ASSERT_NOW(a_verdict_shape, clock, reset, rsp_tvalid && rsp_tuser == KindVerdict, rsp_tlast && rsp_tdata[7:0] == 8'd0 && rsp_tdata[10:8] <= VerdictTooShort, "malformed verdict item")

   `FCFE_ASSERT_NEXT(a_empty_after_reset, clock, 1'b0, reset, !rsp_tvalid, "result shown right after reset")

endmodule

bind frame_checker_and_field_extractor_core fcfe_checker u_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Testbench for the frame checker core: directed and random frames against a byte-level predictor.
module tb;
   import fcfe_pkg::*;

   localparam int CycleLimit   = 12_000_000;
   localparam int SettleCycles = 8;

   // Header faults a built frame may carry, combined as a bit set
   localparam int FaultNone   = 0;
   localparam int FaultType   = 1;
   localparam int FaultSum    = 2;
   localparam int FaultLength = 4;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      verdict_type verdict;
      logic [15:0] payload_length;
      logic [7:0]  packet_number;
      logic [7:0]  packet_count;
      logic [15:0] frame_sequence;
      logic [63:0] device_ident;
      logic        last;
   } rsp_expect_type;

   class frame_scoreboard;
      logic [7:0]  accepted_type;
      logic [15:0] byte_pos;
      logic [19:0] sum_acc;
      logic [7:0]  low_hold;
      logic [7:0]  type_seen;
      logic [15:0] length_field;
      logic [15:0] rx_checksum;
      logic [31:0] index_fields;
      logic [63:0] ident_bytes;
      rsp_expect_type expected_rsps[$];
      int          error_count;
      int          checked_count;

      function new();
         accepted_type = TypeReset;
         error_count = 0;
         checked_count = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         byte_pos = '0;
         sum_acc = '0;
         low_hold = '0;
         type_seen = '0;
         length_field = '0;
         rx_checksum = '0;
         index_fields = '0;
         ident_bytes = '0;
      endfunction

      static function logic [15:0] inverted_fold(logic [19:0] s);
         logic [20:0] t;
         t = s;
         while (t[20:16] != 0)
            t = t[15:0] + t[20:16];
         return ~t[15:0];
      endfunction

      // Advance the header state by one accepted byte and queue what it causes.
      function void predict_byte(logic [7:0] b, logic last);
         logic [16:0] frame_len;
         logic [15:0] plen;
         verdict_type v;
         rsp_expect_type e;
         if (byte_pos < SumBytes) begin
            if (!byte_pos[0])
               low_hold = b;
            else
               sum_acc = sum_acc + {4'b0, b, low_hold};
         end
         if (byte_pos == TypeOffset)
            type_seen = b;
         if (byte_pos >= IdentFirst && byte_pos <= IdentLast)
            ident_bytes = {ident_bytes[55:0], b};
         if (byte_pos >= LengthFirst && byte_pos <= LengthLast)
            length_field = {length_field[7:0], b};
         if (byte_pos == SumBytes || byte_pos == ChecksumLast)
            rx_checksum = {rx_checksum[7:0], b};
         if (byte_pos >= IndexFirst && byte_pos <= IndexLast)
            index_fields = {index_fields[23:0], b};
         if (byte_pos >= PayloadOffset && {1'b0, byte_pos} < MaxFrameBytes) begin
            e = '0;
            e.kind = KindPayload;
            e.payload_byte = b;
            e.last = !last;
            expected_rsps.push_back(e);
         end
         if (last) begin
            frame_len = {1'b0, byte_pos} + 17'd1;
            plen = length_field - LengthBias;
            if (frame_len < {1'b0, PayloadOffset})
               v = VerdictTooShort;
            else if (type_seen != accepted_type)
               v = VerdictWrongType;
            else if (rx_checksum != inverted_fold(sum_acc))
               v = VerdictChecksum;
            else if (frame_len > MaxFrameBytes || plen != frame_len[15:0] - PayloadOffset)
               v = VerdictLength;
            else
               v = VerdictOk;
            e = '0;
            e.kind = KindVerdict;
            e.verdict = v;
            e.payload_length = plen;
            e.packet_number = index_fields[31:24];
            e.packet_count = index_fields[23:16];
            e.frame_sequence = index_fields[15:0];
            e.device_ident = ident_bytes;
            e.last = 1'b1;
            expected_rsps.push_back(e);
            clear_frame();
         end else if (byte_pos != PosSaturate) begin
            byte_pos = byte_pos + 16'd1;
         end
      endfunction

      task report(string what);
         $display("tb: mismatch at %0t: %s", $time, what);
         error_count++;
      endtask

      task check_result(logic kind, logic [127:0] data, logic last);
         rsp_expect_type e;
         string diffs;
         if (expected_rsps.size() == 0) begin
            report($sformatf("result with nothing expected, kind %0d data %h", kind, data));
            return;
         end
         e = expected_rsps.pop_front();
         diffs = "";
         if (kind !== e.kind) diffs = {diffs, " kind"};
         if (data[7:0] !== e.payload_byte) diffs = {diffs, " payload_byte"};
         if (data[10:8] !== e.verdict) diffs = {diffs, " verdict"};
         if (data[26:11] !== e.payload_length) diffs = {diffs, " payload_length"};
         if (data[34:27] !== e.packet_number) diffs = {diffs, " packet_number"};
         if (data[42:35] !== e.packet_count) diffs = {diffs, " packet_count"};
         if (data[58:43] !== e.frame_sequence) diffs = {diffs, " frame_sequence"};
         if (data[122:59] !== e.device_ident) diffs = {diffs, " device_ident"};
         if (last !== e.last) diffs = {diffs, " last"};
         if (diffs != "")
            report($sformatf("result %0d wrong:%s (got kind %0d data %h last %0d, want %p)",
                             checked_count, diffs, kind, data, last, e));
         checked_count++;
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         csr_wr_en;
   logic [7:0]   csr_wr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;

   frame_scoreboard sb = new();
   bit send_gaps  = 1'b1;
   bit rsp_stalls = 1'b1;
   int hold_len   = 0;
   int sent_bytes = 0;

   frame_checker_and_field_extractor_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: errors");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off when asked.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_len) @(posedge clock);
            hold_len = 0;
            rsp_tready <= 1'b1;
         end else if (rsp_stalls && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   task automatic send_byte(input logic [7:0] b, input logic l);
      if (send_gaps && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= l;
      do @(posedge clock); while (!req_tready);
      sb.predict_byte(b, l);
      sent_bytes++;
   endtask

   task automatic finish_sending();
      req_tvalid <= 1'b0;
      req_tlast <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (sb.expected_rsps.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_type(input logic [7:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.accepted_type = v;
      @(posedge clock);
   endtask

   // Build a frame with a consistent header (unless faulted) and send it.
   task automatic send_frame(input int pay_len, input int faults);
      logic [7:0]  fb[$];
      logic [15:0] lenf;
      logic [15:0] ck;
      logic [19:0] s;
      for (int i = 0; i < 24; i++)
         fb.push_back(8'($urandom_range(0, 255)));
      fb[7] = sb.accepted_type;
      if (faults & FaultType)
         fb[7] = sb.accepted_type + 8'($urandom_range(1, 255));
      lenf = 16'(pay_len + 4);
      if (faults & FaultLength)
         lenf = lenf + 16'($urandom_range(1, 65535));
      fb[16] = lenf[15:8];
      fb[17] = lenf[7:0];
      s = '0;
      for (int k = 0; k < 9; k++)
         s = s + {4'b0, fb[2 * k + 1], fb[2 * k]};
      ck = frame_scoreboard::inverted_fold(s);
      if (faults & FaultSum)
         ck = ck ^ 16'($urandom_range(1, 65535));
      fb[18] = ck[15:8];
      fb[19] = ck[7:0];
      for (int i = 0; i < pay_len; i++)
         fb.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < fb.size(); i++)
         send_byte(fb[i], i == fb.size() - 1);
   endtask

   task automatic send_noise(input int n);
      for (int i = 0; i < n; i++)
         send_byte(8'($urandom_range(0, 255)), i == n - 1);
   endtask

   initial begin
      int target;
      int pick;
      int pay_len;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames under the reset type
      send_frame(0, FaultNone);
      send_frame(5, FaultNone);
      send_frame(3, FaultType);
      send_frame(3, FaultSum);
      send_frame(3, FaultLength);
      send_frame(2, FaultType | FaultSum);
      send_frame(2, FaultSum | FaultLength);
      send_noise(1);
      send_noise(23);

      // Hold the receiver off so the result queue fills and req stalls
      finish_sending();
      drain();
      hold_len = 120;
      send_frame(40, FaultNone);
      finish_sending();
      drain();

      write_type(8'h00);
      send_frame(4, FaultNone);
      send_frame(4, FaultType);
      finish_sending();
      drain();
      write_type(8'hff);
      send_frame(4, FaultNone);

      for (int phase = 0; phase < 6; phase++) begin
         finish_sending();
         drain();
         case ($urandom_range(0, 3))
            0: write_type(8'h00);
            1: write_type(8'hff);
            default: write_type(8'($urandom_range(0, 255)));
         endcase
         if (phase == 5) begin
            send_gaps = 1'b0;
            rsp_stalls = 1'b0;
         end
         target = sent_bytes + 20;
         while (sent_bytes < target) begin
            pick = $urandom_range(0, 99);
            pay_len = $urandom_range(0, 40);
            if (pick < 60)
               send_frame(pay_len, FaultNone);
            else if (pick < 80)
               send_frame(pay_len, $urandom_range(1, 7));
            else if (pick < 95)
               send_noise($urandom_range(1, 30));
            else
               send_noise($urandom_range(24, 60));
         end
      end

      finish_sending();
      drain();
      if (sb.error_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
